// ===== design/assert_macros.svh =====
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASV_ASSERT(lbl, prop, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define ASV_ASSERT_IMPL(lbl, ante, cons, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASV_ASSERT(lbl, prop, clk, rst_n)

`define ASV_ASSERT_IMPL(lbl, ante, cons, clk, rst_n)

`endif

`endif

// ===== design/asv_pkg.sv =====
// types and codes of the adjacency stream validator
`default_nettype none

package asv_pkg;

  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_DATA   = 3'd1,
    PH_DEGREE = 3'd2,
    PH_EDGES  = 3'd3,
    PH_DONE   = 3'd4
  } asv_phase_e;

  typedef enum logic [2:0] {
    ROLE_COUNT   = 3'd0,
    ROLE_DATA    = 3'd1,
    ROLE_DEGREE  = 3'd2,
    ROLE_EDGE    = 3'd3,
    ROLE_IGNORED = 3'd4,
    ROLE_END     = 3'd5
  } asv_role_e;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_EMPTY        = 4'd1,
    ST_BAD_COUNT    = 4'd2,
    ST_TRUNC_DATA   = 4'd3,
    ST_TRUNC_DEGREE = 4'd4,
    ST_NEG_DEGREE   = 4'd5,
    ST_TRUNC_EDGES  = 4'd6,
    ST_BAD_EDGE     = 4'd7,
    ST_TRAILING     = 4'd8
  } asv_status_e;

  localparam int unsigned NodeBits  = 31;
  localparam int unsigned ValueBits = 32;

  typedef struct packed {
    asv_role_e             role;
    logic [NodeBits-1:0]   node_index;
    logic [ValueBits-1:0]  value;
    asv_status_e           status;
  } asv_rec_t;

endpackage

`default_nettype wire

// ===== design/asv_word_if.sv =====
// input channel carrying stream words and the end marker
`default_nettype none

interface asv_word_if #(
  parameter int unsigned WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] word;
  logic                        is_end;

  modport source (output valid, output word, output is_end, input ready);
  modport sink   (input valid, input word, input is_end, output ready);
endinterface

`default_nettype wire

// ===== design/asv_rec_if.sv =====
// output channel carrying tagged records
`default_nettype none

interface asv_rec_if;
  logic                                valid;
  logic                                ready;
  asv_pkg::asv_role_e                  role;
  logic [asv_pkg::NodeBits-1:0]        node_index;
  logic signed [asv_pkg::ValueBits-1:0] value;
  asv_pkg::asv_status_e                status;

  modport source (output valid, output role, output node_index, output value,
                  output status, input ready);
  modport sink   (input valid, input role, input node_index, input value,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== design/asv_in_stage.sv =====
// input register stage for stream words
`default_nettype none

module asv_in_stage #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  asv_word_if.sink                         word_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic signed [WORD_BITS-1:0]      word_o,
  output logic                             is_end_o
);

  logic                        valid_q;
  logic signed [WORD_BITS-1:0] word_q;
  logic                        is_end_q;
  logic                        load;

  assign word_i.ready = !valid_q || ready_i;
  assign load         = word_i.valid && word_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (word_i.ready) begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q   <= word_i.word;
      is_end_q <= word_i.is_end;
    end
  end

  assign valid_o  = valid_q;
  assign word_o   = word_q;
  assign is_end_o = is_end_q;

endmodule

`default_nettype wire

// ===== design/asv_parser.sv =====
// parse state and record classification
`default_nettype none

`include "assert_macros.svh"

module asv_parser #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire logic signed [WORD_BITS-1:0] word_i,
  input  wire logic                        is_end_i,
  output asv_pkg::asv_rec_t                rec_o
);

  localparam int unsigned CntBits = WORD_BITS - 1;

  asv_pkg::asv_phase_e  phase_q, phase_d;
  logic [CntBits-1:0]   total_q, total_d;
  logic [CntBits-1:0]   node_q, node_d;
  logic [CntBits-1:0]   left_q, left_d;
  asv_pkg::asv_status_e serr_q, serr_d;
  logic                 bad_edge_q, bad_edge_d;
  logic                 trail_q, trail_d;

  logic                 neg;
  logic [CntBits-1:0]   mag;
  logic signed [63:0]   w_ext;
  logic [63:0]          node_ext;
  logic [CntBits-1:0]   node_inc;
  logic                 last_node;

  assign neg       = word_i[WORD_BITS-1];
  assign mag       = word_i[CntBits-1:0];
  assign w_ext     = 64'(word_i);
  assign node_ext  = 64'(node_q);
  assign node_inc  = node_q + CntBits'(1);
  assign last_node = (node_inc == total_q);

  always_comb begin
    phase_d    = phase_q;
    total_d    = total_q;
    node_d     = node_q;
    left_d     = left_q;
    serr_d     = serr_q;
    bad_edge_d = bad_edge_q;
    trail_d    = trail_q;

    rec_o.role       = asv_pkg::ROLE_IGNORED;
    rec_o.node_index = '0;
    rec_o.value      = w_ext[asv_pkg::ValueBits-1:0];
    rec_o.status     = asv_pkg::ST_OK;

    if (is_end_i) begin
      rec_o.role  = asv_pkg::ROLE_END;
      rec_o.value = '0;
      if (serr_q != asv_pkg::ST_OK) begin
        rec_o.status = serr_q;
      end else begin
        case (phase_q)
          asv_pkg::PH_COUNT:  rec_o.status = asv_pkg::ST_EMPTY;
          asv_pkg::PH_DATA:   rec_o.status = asv_pkg::ST_TRUNC_DATA;
          asv_pkg::PH_DEGREE: rec_o.status = asv_pkg::ST_TRUNC_DEGREE;
          asv_pkg::PH_EDGES:  rec_o.status = asv_pkg::ST_TRUNC_EDGES;
          default: begin
            if (bad_edge_q) begin
              rec_o.status = asv_pkg::ST_BAD_EDGE;
            end else if (trail_q) begin
              rec_o.status = asv_pkg::ST_TRAILING;
            end else begin
              rec_o.status = asv_pkg::ST_OK;
            end
          end
        endcase
      end
      phase_d    = asv_pkg::PH_COUNT;
      total_d    = '0;
      node_d     = '0;
      left_d     = '0;
      serr_d     = asv_pkg::ST_OK;
      bad_edge_d = 1'b0;
      trail_d    = 1'b0;
    end else if (serr_q != asv_pkg::ST_OK) begin
      rec_o.role = asv_pkg::ROLE_IGNORED;
    end else begin
      case (phase_q)
        asv_pkg::PH_COUNT: begin
          rec_o.role = asv_pkg::ROLE_COUNT;
          if (neg) begin
            serr_d = asv_pkg::ST_BAD_COUNT;
          end else begin
            total_d = mag;
            node_d  = '0;
            phase_d = (mag == '0) ? asv_pkg::PH_DONE : asv_pkg::PH_DATA;
          end
        end
        asv_pkg::PH_DATA: begin
          rec_o.role       = asv_pkg::ROLE_DATA;
          rec_o.node_index = node_ext[asv_pkg::NodeBits-1:0];
          phase_d          = asv_pkg::PH_DEGREE;
        end
        asv_pkg::PH_DEGREE: begin
          rec_o.role       = asv_pkg::ROLE_DEGREE;
          rec_o.node_index = node_ext[asv_pkg::NodeBits-1:0];
          if (neg) begin
            serr_d = asv_pkg::ST_NEG_DEGREE;
          end else if (mag == '0) begin
            node_d  = node_inc;
            phase_d = last_node ? asv_pkg::PH_DONE : asv_pkg::PH_DATA;
          end else begin
            left_d  = mag;
            phase_d = asv_pkg::PH_EDGES;
          end
        end
        asv_pkg::PH_EDGES: begin
          rec_o.role       = asv_pkg::ROLE_EDGE;
          rec_o.node_index = node_ext[asv_pkg::NodeBits-1:0];
          if (neg || (mag >= total_q)) begin
            bad_edge_d = 1'b1;
          end
          left_d = left_q - CntBits'(1);
          if (left_q == CntBits'(1)) begin
            node_d  = node_inc;
            phase_d = last_node ? asv_pkg::PH_DONE : asv_pkg::PH_DATA;
          end
        end
        default: begin
          rec_o.role = asv_pkg::ROLE_IGNORED;
          trail_d    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= asv_pkg::PH_COUNT;
      total_q    <= '0;
      node_q     <= '0;
      left_q     <= '0;
      serr_q     <= asv_pkg::ST_OK;
      bad_edge_q <= 1'b0;
      trail_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      total_q    <= total_d;
      node_q     <= node_d;
      left_q     <= left_d;
      serr_q     <= serr_d;
      bad_edge_q <= bad_edge_d;
      trail_q    <= trail_d;
    end
  end

  `ASV_ASSERT_IMPL(a_end_clears, fire_i && is_end_i, phase_q == asv_pkg::PH_COUNT && serr_q == asv_pkg::ST_OK && !bad_edge_q && !trail_q, clk_i, rst_ni)
  `ASV_ASSERT(a_node_in_range, (phase_q == asv_pkg::PH_COUNT) || (phase_q == asv_pkg::PH_DONE) || (node_q < total_q), clk_i, rst_ni)
  `ASV_ASSERT(a_edges_pending, (phase_q != asv_pkg::PH_EDGES) || (left_q != '0), clk_i, rst_ni)

endmodule

`default_nettype wire

// ===== design/asv_out_stage.sv =====
// result register driving the record channel
`default_nettype none

`include "assert_macros.svh"

module asv_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire asv_pkg::asv_rec_t rec_i,
  asv_rec_if.source              rec_o
);

  logic              valid_q;
  asv_pkg::asv_rec_t rec_q;

  assign ready_o = !valid_q || rec_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o.valid      = valid_q;
  assign rec_o.role       = rec_q.role;
  assign rec_o.node_index = rec_q.node_index;
  assign rec_o.value      = rec_q.value;
  assign rec_o.status     = rec_q.status;

  `ASV_ASSERT(a_end_record_clean, !valid_q || (rec_q.role != asv_pkg::ROLE_END) || (rec_q.node_index == '0 && rec_q.value == '0), clk_i, rst_ni)
  `ASV_ASSERT(a_status_only_at_end, !valid_q || (rec_q.role == asv_pkg::ROLE_END) || (rec_q.status == asv_pkg::ST_OK), clk_i, rst_ni)

endmodule

`default_nettype wire

// ===== design/adjacency_stream_validator.sv =====
// top level of the adjacency stream validator
`default_nettype none

// Takes one stream word or end marker per cycle while the record channel is not stalled,
// and returns one tagged record per item through the input register and the result register.
// The parse state (phase, node and edge counters, latched errors) updates once per item with
// a single decrement and compare, and a stalled record channel holds the input side back
// only once both registers are full. No clearing pass is needed after reset; an end marker
// returns the parse state to its reset values for the next stream.
module adjacency_stream_validator #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  asv_word_if.sink   word_i,
  asv_rec_if.source  rec_o
);

  logic                        s1_valid;
  logic                        s1_ready;
  logic signed [WORD_BITS-1:0] s1_word;
  logic                        s1_is_end;
  asv_pkg::asv_rec_t           rec;

  asv_in_stage #(
    .WORD_BITS (WORD_BITS)
  ) u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (word_i),
    .valid_o  (s1_valid),
    .ready_i  (s1_ready),
    .word_o   (s1_word),
    .is_end_o (s1_is_end)
  );

  asv_parser #(
    .WORD_BITS (WORD_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_valid && s1_ready),
    .word_i   (s1_word),
    .is_end_i (s1_is_end),
    .rec_o    (rec)
  );

  asv_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .rec_i   (rec),
    .rec_o   (rec_o)
  );

endmodule

`default_nettype wire
